FILE: src/mftt_pkg.sv
package mftt_pkg;

    // Build-time defaults for the top-level parameters
    localparam int MOTORS_DEF = 8;
    localparam int CPT_DEF    = 8192;

    // Slot field is sized for the largest supported motor count
    localparam int MOTORS_MAX = 32;
    localparam int SLOT_W     = $clog2(MOTORS_MAX);

    localparam logic [14:0] WRAP_RESET = 15'd8000;

    // Motor kind codes carried by the input beat
    typedef enum logic {
        KIND_DIRECT = 1'b0,
        KIND_GEARED = 1'b1
    } motor_kind_t;

    // Decoupling queue between classifier and datapath
    localparam int QUEUE_DEPTH = 2;

    // rps_q16 = speed * 65536 / 60    = speed * 16384 / 15
    //         = speed * 65536 / 1140  = speed * 16384 / 285
    // Quotient by reciprocal multiply, then one correction step.
    localparam int DIV_DIRECT = 15;
    localparam int DIV_GEARED = 285;
    localparam int SH_DIRECT  = 34;
    localparam int SH_GEARED  = 38;
    localparam logic [30:0] RECIP_DIRECT = 31'((64'd1 << SH_DIRECT) / DIV_DIRECT);
    localparam logic [30:0] RECIP_GEARED = 31'((64'd1 << SH_GEARED) / DIV_GEARED);

    // One classified frame as it sits in the queue
    typedef struct packed {
        logic                id_err;
        logic                geared;
        logic [SLOT_W-1:0]   slot;
        logic signed [15:0]  angle;
        logic signed [15:0]  speed;
        logic signed [15:0]  current;
        logic [7:0]          temp;
        logic                spd_neg;
        logic [29:0]         spd_mag;   // |speed| * 16384
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: src/mftt_front.sv
module mftt_front #(
    parameter int MOTORS = mftt_pkg::MOTORS_DEF
) (
    input  logic [7:0]      motor_id,
    input  logic            motor_kind,
    input  logic [63:0]     payload,
    output mftt_pkg::item_t item
);
    import mftt_pkg::*;

    logic        in_range;
    logic [15:0] spd_raw;
    logic [15:0] spd_abs;
    logic [7:0]  id_m1;

    assign in_range = (motor_id != 8'd0) && (motor_id <= 8'(MOTORS));
    assign spd_raw  = payload[47:32];
    assign spd_abs  = spd_raw[15] ? (~spd_raw + 16'd1) : spd_raw;
    assign id_m1    = motor_id - 8'd1;

    // Bad IDs go down the pipe as an all-zero beat with only the flag set
    always_comb begin
        item = '0;
        if (!in_range) begin
            item.id_err = 1'b1;
        end else begin
            item.geared  = (motor_kind == KIND_GEARED);
            item.slot    = id_m1[SLOT_W-1:0];
            item.angle   = payload[63:48];
            item.speed   = spd_raw;
            item.current = payload[31:16];
            item.temp    = payload[15:8];
            item.spd_neg = spd_raw[15];
            item.spd_mag = {spd_abs, 14'd0};
        end
    end

endmodule

FILE: src/mftt_fifo.sv
module mftt_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  mftt_pkg::item_t     wr_item,
    input  logic                rd_en,
    output mftt_pkg::item_t     rd_item,
    output mftt_pkg::q_status_t status
);
    import mftt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign status.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_item      = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: src/mftt_back.sv
module mftt_back #(
    parameter int MOTORS          = mftt_pkg::MOTORS_DEF,
    parameter int COUNTS_PER_TURN = mftt_pkg::CPT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [14:0]        wrap_threshold,
    input  mftt_pkg::item_t    q_item,
    input  logic               q_valid,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_id_error,
    output logic signed [15:0] m_rotor_angle,
    output logic signed [15:0] m_rotor_speed,
    output logic signed [15:0] m_drive_current,
    output logic [7:0]         m_temperature,
    output logic signed [26:0] m_speed_rps_q16,
    output logic signed [15:0] m_turn_count,
    output logic signed [29:0] m_total_counts
);
    import mftt_pkg::*;

    localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam logic signed [17:0] CPT_S   = 18'(COUNTS_PER_TURN);
    localparam logic signed [34:0] TOT_MAX = 35'sd536870911;
    localparam logic signed [34:0] TOT_MIN = -35'sd536870912;
    localparam logic signed [15:0] T_MAX   = 16'sh7FFF;
    localparam logic signed [15:0] T_MIN   = 16'sh8000;

    // Per-motor tracking state
    logic signed [15:0] prev_angle_reg  [MOTORS];
    logic signed [15:0] turns_store_reg [MOTORS];

    logic en;

    // stage 1: state update
    logic [IDX_W-1:0]   idx;
    logic               track;
    logic signed [15:0] cur_t, cur_p, t_next;
    logic signed [16:0] diff, thr_pos, thr_neg;

    logic               s1_valid_reg;
    item_t              s1_item_reg;
    logic signed [15:0] s1_turns_reg;

    // stage 2: multiplies
    logic [60:0]        rps_prod;
    logic [60:0]        rps_shift;
    logic signed [33:0] tprod;

    logic               s2_valid_reg;
    logic               s2_err_reg, s2_geared_reg, s2_neg_reg;
    logic signed [15:0] s2_angle_reg, s2_speed_reg, s2_current_reg, s2_turns_reg;
    logic [7:0]         s2_temp_reg;
    logic [29:0]        s2_mag_reg;
    logic [25:0]        s2_q0_reg;
    logic signed [33:0] s2_tprod_reg;

    // stage 3: quotient fix-up, total, saturation
    logic [8:0]         divisor;
    logic [29:0]        dq, rem;
    logic [25:0]        q_fix;
    logic signed [26:0] rps;
    logic signed [34:0] sum;
    logic signed [29:0] total;

    logic               s3_valid_reg;
    logic               err_reg;
    logic signed [15:0] angle_reg, speed_reg, current_reg, turns_reg;
    logic [7:0]         temp_reg;
    logic signed [26:0] rps_reg;
    logic signed [29:0] total_reg;

    assign en    = !s3_valid_reg || m_ready;
    assign q_pop = en && q_valid;

    assign idx     = q_item.slot[IDX_W-1:0];
    assign track   = !q_item.id_err && !q_item.geared;
    assign cur_t   = turns_store_reg[idx];
    assign cur_p   = prev_angle_reg[idx];
    assign diff    = {q_item.angle[15], q_item.angle} - {cur_p[15], cur_p};
    assign thr_pos = {2'b00, wrap_threshold};
    assign thr_neg = -thr_pos;

    always_comb begin
        t_next = cur_t;
        if (diff > thr_pos) begin
            if (cur_t != T_MIN) begin
                t_next = cur_t - 16'sd1;
            end
        end else if (diff < thr_neg) begin
            if (cur_t != T_MAX) begin
                t_next = cur_t + 16'sd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MOTORS; i++) begin
                prev_angle_reg[i]  <= '0;
                turns_store_reg[i] <= '0;
            end
        end else if (q_pop && track) begin
            prev_angle_reg[idx]  <= q_item.angle;
            turns_store_reg[idx] <= t_next;
        end
    end

    assign rps_prod  = 61'(s1_item_reg.spd_mag) *
                       61'(s1_item_reg.geared ? RECIP_GEARED : RECIP_DIRECT);
    assign rps_shift = s1_item_reg.geared ? (rps_prod >> SH_GEARED) : (rps_prod >> SH_DIRECT);
    assign tprod     = 34'(s1_turns_reg) * 34'(CPT_S);

    assign divisor = s2_geared_reg ? 9'(DIV_GEARED) : 9'(DIV_DIRECT);
    assign dq      = 30'(s2_q0_reg) * 30'(divisor);
    assign rem     = s2_mag_reg - dq;
    assign q_fix   = s2_q0_reg + ((rem >= 30'(divisor)) ? 26'd1 : 26'd0);
    assign rps     = s2_neg_reg ? -27'(q_fix) : 27'(q_fix);
    assign sum     = 35'(s2_tprod_reg) + 35'(s2_angle_reg);

    always_comb begin
        if (s2_geared_reg || s2_err_reg) begin
            total = '0;
        end else if (sum > TOT_MAX) begin
            total = TOT_MAX[29:0];
        end else if (sum < TOT_MIN) begin
            total = TOT_MIN[29:0];
        end else begin
            total = sum[29:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_item_reg  <= q_item;
            s1_turns_reg <= track ? t_next : 16'sd0;

            s2_err_reg     <= s1_item_reg.id_err;
            s2_geared_reg  <= s1_item_reg.geared;
            s2_neg_reg     <= s1_item_reg.spd_neg;
            s2_angle_reg   <= s1_item_reg.angle;
            s2_speed_reg   <= s1_item_reg.speed;
            s2_current_reg <= s1_item_reg.current;
            s2_temp_reg    <= s1_item_reg.temp;
            s2_mag_reg     <= s1_item_reg.spd_mag;
            s2_turns_reg   <= s1_turns_reg;
            s2_q0_reg      <= rps_shift[25:0];
            s2_tprod_reg   <= tprod;

            err_reg     <= s2_err_reg;
            angle_reg   <= s2_angle_reg;
            speed_reg   <= s2_speed_reg;
            current_reg <= s2_current_reg;
            temp_reg    <= s2_temp_reg;
            turns_reg   <= s2_turns_reg;
            rps_reg     <= rps;
            total_reg   <= total;
        end
    end

    assign m_valid         = s3_valid_reg;
    assign m_id_error      = err_reg;
    assign m_rotor_angle   = angle_reg;
    assign m_rotor_speed   = speed_reg;
    assign m_drive_current = current_reg;
    assign m_temperature   = temp_reg;
    assign m_speed_rps_q16 = rps_reg;
    assign m_turn_count    = turns_reg;
    assign m_total_counts  = total_reg;

endmodule

FILE: src/motor_feedback_turn_tracker.sv
// Motor feedback decoder with multi-turn tracking. Each input beat is one
// feedback frame (motor number, kind, 8 payload bytes with byte 0 in the top
// bits); each beat yields exactly one result beat, in order. Angle, speed and
// current are big-endian signed words from bytes 0-1, 2-3, 4-5; byte 6 is the
// temperature and byte 7 is dropped. Speed is converted to output-shaft rev/s
// in Q16 (rpm/60, or rpm/1140 for the geared kind), truncated toward zero.
// Direct-drive frames update a per-motor last angle and saturating turn count
// (a jump above wrap_threshold steps one turn down, below -wrap_threshold one
// turn up) and report turns*COUNTS_PER_TURN + angle, clamped to 30 bits.
// Geared frames leave the tracking state alone and report zero turns/total.
// Motor numbers outside 1..MOTORS return id_error with every other field zero
// and no state change. Throughput is one beat per clock with m_ready high:
// the classifier feeds a 2-entry queue, and the back end does the per-motor
// read-modify-write in a single stage so consecutive frames for the same
// motor chain correctly. Results come from the registered back-end pipeline.
// Write wrap_threshold only while no frames are in flight.
module motor_feedback_turn_tracker #(
    parameter int MOTORS          = mftt_pkg::MOTORS_DEF,
    parameter int COUNTS_PER_TURN = mftt_pkg::CPT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    // config write channel (wrap_threshold)
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        cfg_data,

    // frame input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_motor_id,
    input  logic               s_motor_kind,
    input  logic [63:0]        s_payload,

    // decoded result
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_id_error,
    output logic signed [15:0] m_rotor_angle,
    output logic signed [15:0] m_rotor_speed,
    output logic signed [15:0] m_drive_current,
    output logic [7:0]         m_temperature,
    output logic signed [26:0] m_speed_rps_q16,
    output logic signed [15:0] m_turn_count,
    output logic signed [29:0] m_total_counts
);
    import mftt_pkg::*;

    logic [14:0] wrap_reg;
    item_t       fe_item;
    item_t       q_item;
    q_status_t   q_st;
    logic        q_pop;

    // Config is always takeable; single register, no address
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg <= WRAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            wrap_reg <= cfg_data;
        end
    end

    // Input side stalls only when the queue is full
    assign s_ready = !q_st.full;

    mftt_front #(
        .MOTORS (MOTORS)
    ) u_front (
        .motor_id   (s_motor_id),
        .motor_kind (s_motor_kind),
        .payload    (s_payload),
        .item       (fe_item)
    );

    mftt_fifo u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_valid && s_ready),
        .wr_item (fe_item),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .status  (q_st)
    );

    mftt_back #(
        .MOTORS          (MOTORS),
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .wrap_threshold  (wrap_reg),
        .q_item          (q_item),
        .q_valid         (!q_st.empty),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_id_error      (m_id_error),
        .m_rotor_angle   (m_rotor_angle),
        .m_rotor_speed   (m_rotor_speed),
        .m_drive_current (m_drive_current),
        .m_temperature   (m_temperature),
        .m_speed_rps_q16 (m_speed_rps_q16),
        .m_turn_count    (m_turn_count),
        .m_total_counts  (m_total_counts)
    );

    // Queue status flags are mutually exclusive
    a_q_flags : assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_st.full && q_st.empty))
        else $error("queue reports full and empty at once");

    // A flagged beat carries zero angle, speed, rev/s, turn count and total
    a_err_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_id_error) |->
            (m_rotor_angle == 16'sd0 && m_rotor_speed == 16'sd0 &&
             m_speed_rps_q16 == 27'sd0 && m_turn_count == 16'sd0 &&
             m_total_counts == 30'sd0))
        else $error("id_error beat with nonzero fields");

    // rev/s follows the sign of rpm (truncation toward zero)
    a_rps_neg : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_id_error && m_rotor_speed[15]) |-> (m_speed_rps_q16 <= 27'sd0))
        else $error("negative rpm gave positive rev/s");

    a_rps_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_id_error && !m_rotor_speed[15]) |-> !m_speed_rps_q16[26])
        else $error("non-negative rpm gave negative rev/s");

endmodule

FILE: tb/tb_motor_feedback_turn_tracker.sv
module tb_motor_feedback_turn_tracker;
    import mftt_pkg::*;

    localparam int MOTORS          = MOTORS_DEF;
    localparam int COUNTS_PER_TURN = CPT_DEF;

    // Datapath latency with a free output; wait_idle adds margin for drains
    localparam int PIPE_LAT    = 3;
    // Cycles without any accepted beat before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Long output hold-off used to fill the block and stall its input
    localparam int LONG_HOLD   = 300;

    localparam longint TOTAL_MAX = 64'sd536870911;
    localparam longint TOTAL_MIN = -64'sd536870912;

    // One decoded feedback result as the block should present it
    typedef struct packed {
        logic               id_error;
        logic signed [15:0] angle;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         temp;
        logic signed [26:0] rps_q16;
        logic signed [15:0] turns;
        logic signed [29:0] total;
    } feedback_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [14:0] cfg_data;

    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_motor_id;
    logic        s_motor_kind;
    logic [63:0] s_payload;

    logic               m_valid;
    logic               m_ready;
    logic               m_id_error;
    logic signed [15:0] m_rotor_angle;
    logic signed [15:0] m_rotor_speed;
    logic signed [15:0] m_drive_current;
    logic [7:0]         m_temperature;
    logic signed [26:0] m_speed_rps_q16;
    logic signed [15:0] m_turn_count;
    logic signed [29:0] m_total_counts;

    // Shadow of the block's tracking state and register
    logic [14:0]        wrap_thr;
    logic signed [15:0] angle_shadow [MOTORS];
    int                 turn_tally [MOTORS];

    feedback_t expected_results [$];
    int        mismatch_count = 0;

    // Idling controls: sender gap and receiver stall per beat
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    int hold_cycles  = 0;
    int stall_cycles = 0;
    int quiet_cycles = 0;

    motor_feedback_turn_tracker #(
        .MOTORS          (MOTORS),
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_motor_id      (s_motor_id),
        .s_motor_kind    (s_motor_kind),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_id_error      (m_id_error),
        .m_rotor_angle   (m_rotor_angle),
        .m_rotor_speed   (m_rotor_speed),
        .m_drive_current (m_drive_current),
        .m_temperature   (m_temperature),
        .m_speed_rps_q16 (m_speed_rps_q16),
        .m_turn_count    (m_turn_count),
        .m_total_counts  (m_total_counts)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame decoder: computes the result of one accepted frame and
    // advances the shadow tracking state in acceptance order.
    // ------------------------------------------------------------------
    function automatic feedback_t decode_frame(logic [7:0] id, motor_kind_t kind,
                                               logic [63:0] pl);
        feedback_t          r;
        logic signed [15:0] ang;
        logic signed [15:0] spd;
        int                 slot;
        int                 diff;
        int                 t;
        longint             q;
        longint             acc;
        r = '0;
        // out-of-range motor number: flag only, everything else zero, state untouched
        if (id < 1 || id > MOTORS) begin
            r.id_error = 1'b1;
            return r;
        end
        ang = pl[63:48];
        spd = pl[47:32];
        r.angle   = ang;
        r.speed   = spd;
        r.current = pl[31:16];
        r.temp    = pl[15:8];
        // rpm -> rev/s in Q16; geared kind also divides by the 19:1 ratio.
        // SV integer division truncates toward zero, as required.
        q = longint'(spd) * 65536;
        q = (kind == KIND_GEARED) ? q / 1140 : q / 60;
        r.rps_q16 = q[26:0];
        if (kind == KIND_DIRECT) begin
            slot = id - 1;
            diff = int'(ang) - int'(angle_shadow[slot]);
            t    = turn_tally[slot];
            // forward wrap (large positive jump) means one turn back, and vice versa
            if (diff > int'(wrap_thr)) begin
                if (t > -32768)
                    t--;
            end else if (diff < -int'(wrap_thr)) begin
                if (t < 32767)
                    t++;
            end
            turn_tally[slot]   = t;
            angle_shadow[slot] = ang;
            acc = longint'(t) * COUNTS_PER_TURN + longint'(ang);
            if (acc > TOTAL_MAX)
                acc = TOTAL_MAX;
            if (acc < TOTAL_MIN)
                acc = TOTAL_MIN;
            r.turns = t[15:0];
            r.total = acc[29:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] pack_frame(logic [15:0] ang, logic [15:0] spd,
                                               logic [15:0] cur, logic [7:0] tmp);
        // byte 7 is don't-care for the block, so keep it random
        return {ang, spd, cur, tmp, 8'($urandom)};
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch @%0t: %s got %0d exp %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Frame sender: optional random gap, then hold valid until accepted.
    // Everything changes on the falling edge; acceptance is seen at the
    // rising edge where valid and ready are both high.
    // ------------------------------------------------------------------
    task automatic send_frame(logic [7:0] id, motor_kind_t kind, logic [63:0] pl);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_motor_id   = id;
        s_motor_kind = kind;
        s_payload    = pl;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(decode_frame(id, kind, pl));
    endtask

    task automatic send_angle(logic [7:0] id, logic [15:0] ang);
        send_frame(id, KIND_DIRECT,
                   pack_frame(ang, 16'($urandom), 16'($urandom), 8'($urandom)));
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LAT + 1) @(posedge aclk);
    endtask

    task automatic write_wrap(logic [14:0] thr);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = thr;
        do @(posedge aclk); while (!cfg_ready);
        wrap_thr = thr;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Move a motor's angle to target without counting turns: with the
    // threshold at max, steps of at most 32767 never cross it. Leaves the
    // threshold at zero so every subsequent move counts.
    task automatic coast_to(logic [7:0] id, logic signed [15:0] target);
        int cur;
        int hop;
        wait_idle();
        write_wrap(15'h7FFF);
        cur = angle_shadow[id - 1];
        while (cur != target) begin
            hop = int'(target) - cur;
            if (hop > 32767)
                hop = 32767;
            if (hop < -32767)
                hop = -32767;
            cur += hop;
            send_angle(id, 16'(cur));
        end
        wait_idle();
        write_wrap('0);
    endtask

    // Walk the angle by a fixed stride; with threshold zero each beat is one turn
    task automatic ramp_angle(logic [7:0] id, int stride, int count);
        logic signed [15:0] cur;
        cur = angle_shadow[id - 1];
        repeat (count) begin
            cur += 16'(stride);
            send_angle(id, cur);
        end
    endtask

    // Mostly well-formed tracking traffic: valid motors, most angle moves sized
    // around the threshold so wraps land on both sides of it, the rest fully random;
    // a few frames with arbitrary motor numbers and fully random angles.
    task automatic send_random_frame();
        int          roll;
        int          span;
        int          delta;
        logic [7:0]  id;
        motor_kind_t kind;
        logic [63:0] pl;
        roll = $urandom_range(0, 99);
        id   = (roll < 8) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, MOTORS));
        kind = ($urandom_range(0, 3) == 0) ? KIND_GEARED : KIND_DIRECT;
        pl   = {$urandom, $urandom};
        if (roll >= 8 && roll < 70 && id >= 1 && id <= MOTORS) begin
            span  = 2 * int'(wrap_thr) + 2;
            delta = int'($urandom_range(0, span)) - int'(wrap_thr) - 1;
            pl[63:48] = 16'(int'(angle_shadow[id - 1]) + delta);
        end
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
                0: pl[47:32] = 16'h7FFF;
                1: pl[47:32] = 16'h8000;
                2: pl[47:32] = 16'h0000;
                default: pl[47:32] = 16'hFFFF;
            endcase
        end
        send_frame(id, kind, pl);
    endtask

    // ------------------------------------------------------------------
    // Output side: receiver ready generation and result checking
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else if (stall_cycles > 0) begin
                m_ready = 1'b0;
                stall_cycles--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        feedback_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_id_error !== want.id_error)
                    report_mismatch("id_error", m_id_error, want.id_error);
                if (m_rotor_angle !== want.angle)
                    report_mismatch("rotor_angle", m_rotor_angle, want.angle);
                if (m_rotor_speed !== want.speed)
                    report_mismatch("rotor_speed", m_rotor_speed, want.speed);
                if (m_drive_current !== want.current)
                    report_mismatch("drive_current", m_drive_current, want.current);
                if (m_temperature !== want.temp)
                    report_mismatch("temperature", m_temperature, want.temp);
                if (m_speed_rps_q16 !== want.rps_q16)
                    report_mismatch("speed_rps_q16", m_speed_rps_q16, want.rps_q16);
                if (m_turn_count !== want.turns)
                    report_mismatch("turn_count", m_turn_count, want.turns);
                if (m_total_counts !== want.total)
                    report_mismatch("total_counts", m_total_counts, want.total);
            end
            stall_cycles = rx_idle ? $urandom_range(0, 11) : 0;
        end
    end

    // Watchdog: any accepted beat on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, bad motor numbers, both kinds, threshold boundary at
    // the reset value, motor independence, geared frames not touching state.
    task automatic test_directed();
        send_frame(8'd0, KIND_DIRECT, {$urandom, $urandom});
        send_frame(8'd9, KIND_DIRECT, {$urandom, $urandom});
        send_frame(8'd255, KIND_GEARED, 64'hFFFF_FFFF_FFFF_FFFF);
        // max positive jump from zero: one turn back; then full swing: one forward
        send_frame(8'd1, KIND_DIRECT, pack_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hFF));
        send_frame(8'd1, KIND_DIRECT, pack_frame(16'h8000, 16'h8000, 16'h8000, 8'h00));
        send_frame(8'd8, KIND_GEARED, pack_frame(16'h7FFF, 16'h7FFF, 16'h0001, 8'h80));
        send_frame(8'd8, KIND_GEARED, pack_frame(16'h8000, 16'h8000, 16'hFFFF, 8'h01));
        send_frame(8'd8, KIND_GEARED, pack_frame(16'h0000, 16'hFFFF, 16'h0000, 8'h00));
        // sub-unit truncation toward zero in both signs
        send_frame(8'd2, KIND_DIRECT, pack_frame(16'd0, 16'd59, 16'h1234, 8'h55));
        send_frame(8'd2, KIND_DIRECT, pack_frame(16'd8000, -16'sd59, 16'h4321, 8'hAA));
        // jump equal to the threshold does not count, one past it does
        send_angle(8'd2, 16'd16001);
        send_angle(8'd2, 16'd8001);
        send_angle(8'd3, 16'd20000);
        send_angle(8'd2, 16'd1);
        send_angle(8'd2, -16'sd8000);
        send_angle(8'd3, 16'd20000);
        send_angle(8'd8, 16'h7FFF);
        // geared frame on a tracked motor leaves its angle and count alone
        send_frame(8'd1, KIND_GEARED, pack_frame(16'h0000, 16'd1140, 16'd0, 8'd25));
        send_angle(8'd1, 16'h8000);
        wait_idle();
    endtask

    // Threshold at zero and at max, with jumps landing on and past it
    task automatic test_wrap_extremes();
        write_wrap('0);
        send_angle(8'd4, 16'd0);
        send_angle(8'd4, 16'd1);
        send_angle(8'd4, 16'd0);
        send_angle(8'd4, 16'd0);
        wait_idle();
        write_wrap(15'h7FFF);
        send_angle(8'd4, 16'h7FFF);
        send_angle(8'd4, 16'hFFFF);
        send_angle(8'd4, 16'h7FFF);
        send_angle(8'd4, 16'h8000);
        wait_idle();
    endtask

    // Output held off long enough to back the block up into its input,
    // sender offering back to back; then sender waits for a full drain.
    task automatic test_backpressure();
        write_wrap(15'($urandom_range(1, 32766)));
        tx_idle     = 1'b0;
        hold_cycles = LONG_HOLD;
        repeat (24) send_random_frame();
        wait_idle();
        tx_idle = 1'b1;
    endtask

    // Threshold zero makes every one-count step a turn, so the count moves
    // once per beat; the ramps cross the angle wrap in both directions.
    // No idling keeps this stretch at full rate.
    task automatic test_turn_ramp();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        coast_to(8'd8, 16'sd32700);
        ramp_angle(8'd8, 1, 150);
        ramp_angle(8'd8, -1, 150);
        wait_idle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic random_phase(logic [14:0] thr, int count);
        wait_idle();
        write_wrap(thr);
        for (int i = 0; i < count; i++) begin
            // idling switched per stretch so some stretches run flat out
            if (i % 64 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            send_random_frame();
        end
    endtask

    task automatic test_random();
        random_phase(15'($urandom_range(1, 32766)), 300);
        random_phase('0, 300);
        random_phase(15'h7FFF, 300);
        random_phase(WRAP_RESET, 300);
        wait_idle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_motor_id   = '0;
        s_motor_kind = 1'b0;
        s_payload    = '0;
        wrap_thr     = WRAP_RESET;
        for (int i = 0; i < MOTORS; i++) begin
            angle_shadow[i] = '0;
            turn_tally[i]   = 0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_wrap_extremes();
        test_backpressure();
        test_turn_ramp();
        test_random();

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/mftt_pkg.sv
src/mftt_front.sv
src/mftt_fifo.sv
src/mftt_back.sv
src/motor_feedback_turn_tracker.sv
tb/tb_motor_feedback_turn_tracker.sv
